### rtl/gbfs_pkg.sv
// Shared types and constants for the breadth-first search block.
`timescale 1ns / 1ps
`default_nettype none
package gbfs_pkg;

  localparam int NODE_W = 6;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_REPORT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_RESP,
    ST_POP,
    ST_HEAD,
    ST_LIST,
    ST_EDGE,
    ST_OUT_RD,
    ST_OUT_WT
  } gbfs_state_t;

endpackage
`default_nettype wire

### rtl/gbfs_ram.sv
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module gbfs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/graph_breadth_first_search.sv
// Top level: adjacency store and breadth-first search sequencer.
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tuser: op; tdata: from_node, to_node, both_ways
// out_    | out | out_tvalid/tready  | tuser: kind; tdata: node, distance; tlast: last
//
// Add edge: accept, list write, response; a second list write with both_ways.
// Search: accept, then a pop and a head step per reached node, a list read for a
// node with edges, an edge step per stored edge of a reached node, a final pop to
// end the walk, then a queue read and an output step per reported node.
// Reset empties the store at once through per-node list valid bits.
// A stalled output holds the sequencer; the next item is taken while the last
// result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module graph_breadth_first_search #(
  parameter int NODES      = 64,
  parameter int EDGE_SLOTS = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // from_node[5:0], to_node[11:6], both_ways[12], zero
  input  wire  [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // node[5:0], distance[11:6], zero
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);

  localparam int NW = gbfs_pkg::NODE_W;
  localparam int KW = gbfs_pkg::KIND_W;
  localparam int NA = $clog2(NODES);
  localparam int AW = $clog2(EDGE_SLOTS);
  localparam int SW = $clog2(EDGE_SLOTS + 1);
  localparam int QW = $clog2(NODES + 1);
  localparam logic [SW:0] SLOTS_C = (SW + 1)'(EDGE_SLOTS);
  localparam logic [NW:0] NODES_N = (NW + 1)'(NODES);
  localparam logic [QW-1:0] NODES_Q = QW'(NODES);

  gbfs_pkg::gbfs_state_t state_r, state_nxt;

  logic [NW-1:0] in_from, in_to;
  logic          in_both, in_op, in_fire;
  assign in_from = in_tdata[5:0];
  assign in_to   = in_tdata[11:6];
  assign in_both = in_tdata[12];
  assign in_op   = in_tuser[0];
  assign in_fire = in_tvalid && in_tready;

  logic [NW-1:0]    from_r, from_nxt, to_r, to_nxt, hop_r, hop_nxt;
  logic             both_r, both_nxt;
  logic [SW-1:0]    used_r, used_nxt;
  logic [AW-1:0]    slot_a_r, slot_a_nxt, s_r, s_nxt, tail_s_r, tail_s_nxt;
  logic [QW-1:0]    rd_r, rd_nxt, wr_r, wr_nxt;
  logic [NODES-1:0] seen_r, seen_nxt, full_r, full_nxt;
  logic [KW-1:0]    resp_kind_r, resp_kind_nxt;
  logic [NW-1:0]    resp_node_r, resp_node_nxt;

  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt, out_load;
  logic [KW-1:0] out_kind_r, out_kind_nxt;
  logic [NW-1:0] out_node_r, out_node_nxt, out_dist_r, out_dist_nxt;
  logic          out_free;
  assign out_free = !out_valid_r || out_tready;

  logic          tgt_we, nxt_we, head_we, tail_we, q_we;
  logic [AW-1:0] tgt_waddr, nxt_waddr, e_raddr, nxt_wdata, head_wdata, tail_wdata;
  logic [NW-1:0] tgt_wdata, tgt_rdata;
  logic [AW-1:0] nxt_rdata, head_rdata, tail_rdata;
  logic [NA-1:0] ht_waddr, ht_raddr, q_waddr, q_raddr;
  logic [2*NW-1:0] q_wdata, q_rdata;

  gbfs_ram #(.DEPTH(EDGE_SLOTS), .WIDTH(NW)) u_tgt (
    .clk, .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
    .raddr(e_raddr), .rdata(tgt_rdata));
  gbfs_ram #(.DEPTH(EDGE_SLOTS), .WIDTH(AW)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(e_raddr), .rdata(nxt_rdata));
  gbfs_ram #(.DEPTH(NODES), .WIDTH(AW)) u_head (
    .clk, .we(head_we), .waddr(ht_waddr), .wdata(head_wdata),
    .raddr(ht_raddr), .rdata(head_rdata));
  gbfs_ram #(.DEPTH(NODES), .WIDTH(AW)) u_tail (
    .clk, .we(tail_we), .waddr(ht_waddr), .wdata(tail_wdata),
    .raddr(ht_raddr), .rdata(tail_rdata));
  gbfs_ram #(.DEPTH(NODES), .WIDTH(2 * NW)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));

  logic [NW-1:0] q_node, q_hop;
  assign q_node = q_rdata[NW-1:0];
  assign q_hop  = q_rdata[2*NW-1:NW];

  logic          bad_node, no_room, last_edge, take_t, out_is_last;
  logic [AW-1:0] slot, prev_tail;
  assign bad_node = ({1'b0, in_from} >= NODES_N) || ({1'b0, in_to} >= NODES_N);
  assign no_room  = ({1'b0, used_r} + (SW + 1)'(in_both ? 2 : 1)) > SLOTS_C;
  assign slot     = used_r[AW-1:0];
  assign prev_tail = (to_r == from_r) ? slot_a_r : tail_rdata;
  assign last_edge = (s_r == tail_s_r);
  assign take_t   = ({1'b0, tgt_rdata} < NODES_N) && !seen_r[tgt_rdata[NA-1:0]]
                    && (wr_r < NODES_Q);
  assign out_is_last = ((rd_r + QW'(1)) == wr_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbfs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_op == gbfs_pkg::OP_ADD) begin
            state_nxt = (bad_node || no_room) ? gbfs_pkg::ST_RESP : gbfs_pkg::ST_ADD_A;
          end else if ({1'b0, in_from} >= NODES_N) begin
            state_nxt = gbfs_pkg::ST_RESP;
          end else begin
            state_nxt = gbfs_pkg::ST_POP;
          end
        end
      end
      gbfs_pkg::ST_ADD_A: state_nxt = both_r ? gbfs_pkg::ST_ADD_B : gbfs_pkg::ST_RESP;
      gbfs_pkg::ST_ADD_B: state_nxt = gbfs_pkg::ST_RESP;
      gbfs_pkg::ST_RESP: begin
        if (out_free) state_nxt = gbfs_pkg::ST_IDLE;
      end
      gbfs_pkg::ST_POP: begin
        state_nxt = (rd_r == wr_r) ? gbfs_pkg::ST_OUT_RD : gbfs_pkg::ST_HEAD;
      end
      gbfs_pkg::ST_HEAD: begin
        state_nxt = full_r[q_node[NA-1:0]] ? gbfs_pkg::ST_LIST : gbfs_pkg::ST_POP;
      end
      gbfs_pkg::ST_LIST: state_nxt = gbfs_pkg::ST_EDGE;
      gbfs_pkg::ST_EDGE: begin
        if (last_edge) state_nxt = gbfs_pkg::ST_POP;
      end
      gbfs_pkg::ST_OUT_RD: state_nxt = gbfs_pkg::ST_OUT_WT;
      gbfs_pkg::ST_OUT_WT: begin
        if (out_free) state_nxt = out_is_last ? gbfs_pkg::ST_IDLE : gbfs_pkg::ST_OUT_RD;
      end
      default: state_nxt = gbfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == gbfs_pkg::ST_IDLE);
    from_nxt      = from_r;
    to_nxt        = to_r;
    both_nxt      = both_r;
    hop_nxt       = hop_r;
    used_nxt      = used_r;
    slot_a_nxt    = slot_a_r;
    s_nxt         = s_r;
    tail_s_nxt    = tail_s_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    seen_nxt      = seen_r;
    full_nxt      = full_r;
    resp_kind_nxt = resp_kind_r;
    resp_node_nxt = resp_node_r;
    tgt_we        = 1'b0;
    nxt_we        = 1'b0;
    head_we       = 1'b0;
    tail_we       = 1'b0;
    q_we          = 1'b0;
    tgt_waddr     = slot;
    tgt_wdata     = to_r;
    nxt_waddr     = tail_rdata;
    nxt_wdata     = slot;
    head_wdata    = slot;
    tail_wdata    = slot;
    ht_waddr      = from_r[NA-1:0];
    ht_raddr      = q_node[NA-1:0];
    e_raddr       = nxt_rdata;
    q_waddr       = wr_r[NA-1:0];
    q_wdata       = {hop_r + NW'(1), tgt_rdata};
    q_raddr       = rd_r[NA-1:0];
    out_load      = 1'b0;
    out_kind_nxt  = gbfs_pkg::KIND_REPORT;
    out_node_nxt  = q_node;
    out_dist_nxt  = q_hop;
    out_last_nxt  = out_is_last;
    case (state_r)
      gbfs_pkg::ST_IDLE: begin
        ht_raddr      = in_from[NA-1:0];
        from_nxt      = in_from;
        to_nxt        = in_to;
        both_nxt      = in_both;
        resp_node_nxt = '0;
        resp_kind_nxt = (bad_node || no_room) ? gbfs_pkg::KIND_REJECTED
                                              : gbfs_pkg::KIND_STORED;
        if (in_fire && in_op == gbfs_pkg::OP_SEARCH) begin
          resp_kind_nxt = gbfs_pkg::KIND_REPORT;
          resp_node_nxt = in_from;
          if ({1'b0, in_from} < NODES_N) begin
            seen_nxt = '0;
            seen_nxt[in_from[NA-1:0]] = 1'b1;
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = {NW'(0), in_from};
            rd_nxt   = '0;
            wr_nxt   = QW'(1);
          end
        end
      end
      gbfs_pkg::ST_ADD_A: begin
        ht_raddr   = to_r[NA-1:0];
        tgt_we     = 1'b1;
        tail_we    = 1'b1;
        nxt_we     = full_r[from_r[NA-1:0]];
        head_we    = !full_r[from_r[NA-1:0]];
        full_nxt[from_r[NA-1:0]] = 1'b1;
        used_nxt   = used_r + SW'(1);
        slot_a_nxt = slot;
      end
      gbfs_pkg::ST_ADD_B: begin
        tgt_wdata = from_r;
        ht_waddr  = to_r[NA-1:0];
        nxt_waddr = prev_tail;
        tgt_we    = 1'b1;
        tail_we   = 1'b1;
        nxt_we    = full_r[to_r[NA-1:0]];
        head_we   = !full_r[to_r[NA-1:0]];
        full_nxt[to_r[NA-1:0]] = 1'b1;
        used_nxt  = used_r + SW'(1);
      end
      gbfs_pkg::ST_RESP: begin
        out_load     = out_free;
        out_kind_nxt = resp_kind_r;
        out_node_nxt = resp_node_r;
        out_dist_nxt = '0;
        out_last_nxt = 1'b1;
      end
      gbfs_pkg::ST_POP: begin
        if (rd_r == wr_r) begin
          rd_nxt = '0;
        end else begin
          rd_nxt = rd_r + QW'(1);
        end
      end
      gbfs_pkg::ST_HEAD: begin
        hop_nxt = q_hop;
      end
      gbfs_pkg::ST_LIST: begin
        e_raddr    = head_rdata;
        s_nxt      = head_rdata;
        tail_s_nxt = tail_rdata;
      end
      gbfs_pkg::ST_EDGE: begin
        if (take_t) begin
          seen_nxt[tgt_rdata[NA-1:0]] = 1'b1;
          q_we   = 1'b1;
          wr_nxt = wr_r + QW'(1);
        end
        s_nxt = nxt_rdata;
      end
      gbfs_pkg::ST_OUT_RD: begin
      end
      gbfs_pkg::ST_OUT_WT: begin
        if (out_free) begin
          out_load = 1'b1;
          rd_nxt   = rd_r + QW'(1);
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbfs_pkg::ST_IDLE;
      used_r      <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    both_r      <= both_nxt;
    hop_r       <= hop_nxt;
    slot_a_r    <= slot_a_nxt;
    s_r         <= s_nxt;
    tail_s_r    <= tail_s_nxt;
    rd_r        <= rd_nxt;
    wr_r        <= wr_nxt;
    seen_r      <= seen_nxt;
    resp_kind_r <= resp_kind_nxt;
    resp_node_r <= resp_node_nxt;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_node_r <= out_node_nxt;
      out_dist_r <= out_dist_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_dist_r, out_node_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

### tb/sv/graph_breadth_first_search_tb.sv
// Testbench for the breadth-first search block: edge loading, search order and store limits.
`timescale 1ns / 1ps
module graph_breadth_first_search_tb;

  localparam int NODE_CNT  = 64;
  localparam int SLOT_CNT  = 256;
  localparam int NULL_SLOT = SLOT_CNT;
  localparam int LIMIT     = 400000;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] node;
    logic [5:0] depth;
    logic       last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  graph_breadth_first_search DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #1 clk = ~clk;

  logic [5:0] adj_target [SLOT_CNT];
  int         adj_next [SLOT_CNT];
  int         adj_head [NODE_CNT];
  int         adj_tail [NODE_CNT];
  int         slots_used;
  answer_t    pending_answers [$];
  int         errors = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  function automatic void link_edge(int src, int dst);
    adj_target[slots_used] = dst[5:0];
    adj_next[slots_used] = NULL_SLOT;
    if (adj_tail[src] == NULL_SLOT) adj_head[src] = slots_used;
    else adj_next[adj_tail[src]] = slots_used;
    adj_tail[src] = slots_used;
    slots_used++;
  endfunction

  function automatic void predict_item(logic op, logic [5:0] a, logic [5:0] b, logic both);
    bit       visited [NODE_CNT];
    int       hops [NODE_CNT];
    int       order [$];
    int       rd, cur, s, t;
    answer_t  ans;
    if (op == gbfs_pkg::OP_ADD) begin
      ans = '{gbfs_pkg::KIND_REJECTED, 6'd0, 6'd0, 1'b1};
      if (SLOT_CNT - slots_used >= (both ? 2 : 1)) begin
        link_edge(a, b);
        if (both) link_edge(b, a);
        ans.kind = gbfs_pkg::KIND_STORED;
      end
      pending_answers = {pending_answers, ans};
      return;
    end
    foreach (visited[i]) visited[i] = 1'b0;
    order = {int'(a)};
    visited[a] = 1'b1;
    hops[a] = 0;
    rd = 0;
    while (rd < order.size()) begin
      cur = order[rd];
      rd++;
      s = adj_head[cur];
      while (s != NULL_SLOT) begin
        t = adj_target[s];
        if (!visited[t]) begin
          visited[t] = 1'b1;
          hops[t] = (hops[cur] + 1) % 64;
          order = {order, t};
        end
        s = adj_next[s];
      end
    end
    foreach (order[i]) begin
      ans = '{gbfs_pkg::KIND_REPORT, order[i][5:0], hops[order[i]][5:0],
              i == order.size() - 1};
      pending_answers = {pending_answers, ans};
    end
  endfunction

  task automatic send_word(logic op, logic [5:0] a, logic [5:0] b, logic both);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    predict_item(op, a, b, both);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, both, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (!calm && $urandom_range(0, 4) == 0) out_tready <= 1'b0;
      else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word got kind=%0d node=%0d dist=%0d last=%0d",
                 $time, out_tuser, out_tdata[5:0], out_tdata[11:6], out_tlast);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (want.kind !== out_tuser || want.node !== out_tdata[5:0] ||
            want.depth !== out_tdata[11:6] || want.last !== out_tlast) begin
          $display("%0t: expected kind=%0d node=%0d dist=%0d last=%0d got %0d %0d %0d %0d",
                   $time, want.kind, want.node, want.depth, want.last,
                   out_tuser, out_tdata[5:0], out_tdata[11:6], out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_isolated_and_extremes();
    send_word(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0, 1'b0);
    send_word(gbfs_pkg::OP_SEARCH, 6'd63, 6'd63, 1'b1);
    send_word(gbfs_pkg::OP_ADD, 6'd0, 6'd63, 1'b0);
    send_word(gbfs_pkg::OP_ADD, 6'd63, 6'd63, 1'b1);
    send_word(gbfs_pkg::OP_SEARCH, 6'd0, 6'd0, 1'b0);
    send_word(gbfs_pkg::OP_SEARCH, 6'd63, 6'd0, 1'b0);
    drain();
  endtask

  task automatic test_chain_and_fanout();
    for (int i = 1; i < 8; i++) send_word(gbfs_pkg::OP_ADD, i[5:0], 6'(i + 1), 1'b1);
    send_word(gbfs_pkg::OP_ADD, 6'd1, 6'd42, 1'b0);
    send_word(gbfs_pkg::OP_ADD, 6'd42, 6'd21, 1'b0);
    send_word(gbfs_pkg::OP_SEARCH, 6'd1, 6'd0, 1'b0);
    send_word(gbfs_pkg::OP_SEARCH, 6'd8, 6'd0, 1'b1);
    send_word(gbfs_pkg::OP_SEARCH, 6'd21, 6'd0, 1'b0);
    drain();
  endtask

  task automatic test_random_graph();
    int n;
    logic op;
    for (n = 0; n < 40; n++) begin
      op = ($urandom_range(0, 4) == 0) ? gbfs_pkg::OP_SEARCH : gbfs_pkg::OP_ADD;
      if ($urandom_range(0, 3) == 0)
        send_word(op, 6'($urandom), 6'($urandom), 1'($urandom));
      else
        send_word(op, 6'($urandom_range(0, 15)), 6'($urandom_range(0, 15)), 1'($urandom));
    end
    drain();
  endtask

  task automatic test_store_full();
    calm = 1'b0;
    while (slots_used < SLOT_CNT - 1)
      send_word(gbfs_pkg::OP_ADD, 6'($urandom_range(16, 63)), 6'($urandom_range(16, 63)),
                1'b1);
    send_word(gbfs_pkg::OP_ADD, 6'd3, 6'd50, 1'b1);
    send_word(gbfs_pkg::OP_ADD, 6'd50, 6'd3, 1'b0);
    send_word(gbfs_pkg::OP_ADD, 6'd5, 6'd6, 1'b0);
    send_word(gbfs_pkg::OP_ADD, 6'd5, 6'd6, 1'b1);
    calm = 1'b1;
    send_word(gbfs_pkg::OP_SEARCH, 6'd3, 6'd0, 1'b0);
    send_word(gbfs_pkg::OP_SEARCH, 6'd20, 6'd0, 1'b0);
    drain();
  endtask

  initial begin
    foreach (adj_head[i]) begin
      adj_head[i] = NULL_SLOT;
      adj_tail[i] = NULL_SLOT;
    end
    slots_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_isolated_and_extremes();
    test_chain_and_fanout();
    test_random_graph();
    test_store_full();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
